>>> src/sdfc_pkg.sv
// ----------------------------------------------------------------------------
// sdfc_pkg
// shared types, constants and helpers of the contact force block
// ----------------------------------------------------------------------------
package sdfc_pkg;

    localparam int CONTACT_SLOTS = 64;
    localparam int SLOT_W        = 6;
    localparam int CFG_IDX_W     = 3;
    localparam int ROOT_STEPS    = 32;
    localparam int ROOT_CNT_W    = 5;

    localparam logic signed [65:0] MAX32 = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] MIN32 = -66'sh0_8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NORMAL_STIFFNESS  = 3'd0,
        REG_TANGENT_STIFFNESS = 3'd1,
        REG_FRICTION_COEFF    = 3'd2,
        REG_DAMPING_RATIO     = 3'd3,
        REG_TIME_STEP         = 3'd4
    } t_reg_idx;

    typedef enum logic [4:0] {
        OP_NOP, OP_MK, OP_VN1, OP_VN2, OP_VT1, OP_VT2, OP_KG, OP_STEP, OP_KTS,
        OP_VISC, OP_VVN, OP_THR, OP_FX1, OP_FX2, OP_FY1, OP_FY2, OP_MOM1, OP_MOM2
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_DECIDE, S_MK, S_VN1, S_VN2, S_VT1, S_VT2, S_KG, S_STEP, S_GAP1,
        S_KTS, S_ROOT, S_VISC, S_GAP2, S_VVN, S_GAP3, S_THR, S_GAP4, S_CLAMP,
        S_FX1, S_FX2, S_FY1, S_FY2, S_MOM1, S_MOM2, S_FIN
    } t_state;

    typedef struct packed {
        logic load;
        t_op  op;
        logic clamp;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic contact;
        logic root_done;
    } t_sts;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > MAX32) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < MIN32) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> src/sdfc_ctrl.sv
// ----------------------------------------------------------------------------
// sdfc_ctrl
// sequencer issuing at most one multiplier operation per state and owning the beat flags
// ----------------------------------------------------------------------------
module sdfc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output logic            o_valid,
    input  logic            i_stall,
    input  sdfc_pkg::t_sts  i_sts,
    output sdfc_pkg::t_cmd  o_cmd
);
    import sdfc_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid;
    logic   out_blocked;

    assign out_blocked = r_out_valid && i_stall;
    assign o_stall     = (r_state != S_IDLE);
    assign o_valid     = r_out_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_valid) n_state = S_DECIDE;
            S_DECIDE: n_state = i_sts.contact ? S_MK : S_FIN;
            S_MK:     n_state = S_VN1;
            S_VN1:    n_state = S_VN2;
            S_VN2:    n_state = S_VT1;
            S_VT1:    n_state = S_VT2;
            S_VT2:    n_state = S_KG;
            S_KG:     n_state = S_STEP;
            S_STEP:   n_state = S_GAP1;
            S_GAP1:   n_state = S_KTS;
            S_KTS:    n_state = S_ROOT;
            S_ROOT:   if (i_sts.root_done) n_state = S_VISC;
            S_VISC:   n_state = S_GAP2;
            S_GAP2:   n_state = S_VVN;
            S_VVN:    n_state = S_GAP3;
            S_GAP3:   n_state = S_THR;
            S_THR:    n_state = S_GAP4;
            S_GAP4:   n_state = S_CLAMP;
            S_CLAMP:  n_state = S_FX1;
            S_FX1:    n_state = S_FX2;
            S_FX2:    n_state = S_FY1;
            S_FY1:    n_state = S_FY2;
            S_FY2:    n_state = S_MOM1;
            S_MOM1:   n_state = S_MOM2;
            S_MOM2:   n_state = S_FIN;
            S_FIN:    if (!out_blocked) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = OP_NOP;
        o_cmd.load   = (r_state == S_IDLE) && i_valid;
        o_cmd.clamp  = (r_state == S_CLAMP);
        o_cmd.finish = (r_state == S_FIN) && !out_blocked;
        unique case (r_state)
            S_MK:    o_cmd.op = OP_MK;
            S_VN1:   o_cmd.op = OP_VN1;
            S_VN2:   o_cmd.op = OP_VN2;
            S_VT1:   o_cmd.op = OP_VT1;
            S_VT2:   o_cmd.op = OP_VT2;
            S_KG:    o_cmd.op = OP_KG;
            S_STEP:  o_cmd.op = OP_STEP;
            S_KTS:   o_cmd.op = OP_KTS;
            S_VISC:  o_cmd.op = OP_VISC;
            S_VVN:   o_cmd.op = OP_VVN;
            S_THR:   o_cmd.op = OP_THR;
            S_FX1:   o_cmd.op = OP_FX1;
            S_FX2:   o_cmd.op = OP_FX2;
            S_FY1:   o_cmd.op = OP_FY1;
            S_FY2:   o_cmd.op = OP_FY2;
            S_MOM1:  o_cmd.op = OP_MOM1;
            S_MOM2:  o_cmd.op = OP_MOM2;
            default: o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_finish_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> r_state == S_FIN) else $error("finish outside final state");
    a_finish_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid) else $error("result beat not presented");
    a_load_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_DECIDE) else $error("load did not start item");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> o_cmd.op == OP_NOP) else $error("op issued while idle");
`endif

endmodule

>>> src/sdfc_dp.sv
// ----------------------------------------------------------------------------
// sdfc_dp
// shared multiplier, bit-serial root, slot memory, totals and result registers
// ----------------------------------------------------------------------------
module sdfc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  sdfc_pkg::t_cmd                      i_cmd,
    output sdfc_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_we,
    input  logic [sdfc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [31:0]                         i_cfg_data,
    input  logic [sdfc_pkg::SLOT_W-1:0]         i_contact_slot,
    input  logic signed [31:0]                  i_gap,
    input  logic signed [15:0]                  i_normal_x,
    input  logic signed [15:0]                  i_normal_y,
    input  logic signed [15:0]                  i_tangent_x,
    input  logic signed [15:0]                  i_tangent_y,
    input  logic signed [31:0]                  i_rel_vel_x,
    input  logic signed [31:0]                  i_rel_vel_y,
    input  logic [31:0]                         i_point_mass,
    input  logic signed [31:0]                  i_lever_x,
    input  logic signed [31:0]                  i_lever_y,
    input  logic                                i_first_of_sweep,
    output logic                                o_in_contact,
    output logic signed [31:0]                  o_normal_force,
    output logic signed [31:0]                  o_tangent_force,
    output logic signed [31:0]                  o_point_force_x,
    output logic signed [31:0]                  o_point_force_y,
    output logic signed [31:0]                  o_obstacle_force_x,
    output logic signed [31:0]                  o_obstacle_force_y,
    output logic signed [31:0]                  o_obstacle_moment
);
    import sdfc_pkg::*;

    logic [31:0] r_kn, r_kt, r_dt;
    logic [15:0] r_mu, r_dr;

    logic [SLOT_W-1:0]  r_slot;
    logic signed [31:0] r_gap, r_vx, r_vy, r_lx, r_ly;
    logic signed [15:0] r_nx, r_ny, r_tx, r_ty;
    logic [31:0]        r_mass;
    logic               r_contact, r_first;

    logic signed [31:0] r_mem [CONTACT_SLOTS];
    logic [CONTACT_SLOTS-1:0] r_vld;
    logic signed [31:0] r_old;
    logic               r_old_vld;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] r_prod, r_acc, r_kg;
    t_op                r_wb;

    logic signed [31:0] r_vn, r_vt, r_step, r_ft, r_fn, r_fx, r_fy;
    logic [31:0]        r_visc;
    logic signed [37:0] r_thr;

    logic [63:0]        r_rad;
    logic [33:0]        r_rem;
    logic [31:0]        r_root;
    logic [ROOT_CNT_W-1:0] r_cnt;
    logic               r_root_busy;
    logic [35:0]        rem_sh, trial;

    logic signed [31:0] r_sum_fx, r_sum_fy, r_sum_m;
    logic signed [31:0] r_out_fn, r_out_ft, r_out_px, r_out_py;
    logic               r_out_con;

    logic signed [37:0] clamp_lo, clamp_v, neg_thr;
    logic signed [65:0] old_v, mom_v, base_fx, base_fy, base_m;
    logic signed [31:0] ft_sat, sum_fx_n, sum_fy_n, sum_m_n;

    assign o_sts.contact   = r_contact;
    assign o_sts.root_done = !r_root_busy;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kn <= 32'h0001_0000;
            r_kt <= 32'h0001_0000;
            r_mu <= 16'h0800;
            r_dr <= 16'h0000;
            r_dt <= 32'h0001_0000;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NORMAL_STIFFNESS:  r_kn <= i_cfg_data;
                REG_TANGENT_STIFFNESS: r_kt <= i_cfg_data;
                REG_FRICTION_COEFF:    r_mu <= i_cfg_data[15:0];
                REG_DAMPING_RATIO:     r_dr <= i_cfg_data[15:0];
                REG_TIME_STEP:         r_dt <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_slot    <= i_contact_slot;
            r_gap     <= i_gap;
            r_nx      <= i_normal_x;
            r_ny      <= i_normal_y;
            r_tx      <= i_tangent_x;
            r_ty      <= i_tangent_y;
            r_vx      <= i_rel_vel_x;
            r_vy      <= i_rel_vel_y;
            r_mass    <= i_point_mass;
            r_lx      <= i_lever_x;
            r_ly      <= i_lever_y;
            r_first   <= i_first_of_sweep;
            r_contact <= i_gap[31] || (i_gap == 32'sd0);
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_old <= r_mem[i_contact_slot];
        end
        if (i_cmd.clamp) begin
            r_mem[r_slot] <= ft_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_old_vld <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_old_vld <= r_vld[i_contact_slot];
            end
            if (i_cmd.clamp) begin
                r_vld[r_slot] <= 1'b1;
            end else if (i_cmd.finish && !r_contact) begin
                r_vld[r_slot] <= 1'b0;
            end
        end
    end

    // shared multiplier
    always_comb begin
        unique case (i_cmd.op)
            OP_MK:   begin mul_a = {1'b0, r_mass}; mul_b = {1'b0, r_kn}; end
            OP_VN1:  begin mul_a = 33'(r_vx);      mul_b = 33'(r_nx); end
            OP_VN2:  begin mul_a = 33'(r_vy);      mul_b = 33'(r_ny); end
            OP_VT1:  begin mul_a = 33'(r_vx);      mul_b = 33'(r_tx); end
            OP_VT2:  begin mul_a = 33'(r_vy);      mul_b = 33'(r_ty); end
            OP_KG:   begin mul_a = {1'b0, r_kn};   mul_b = 33'(r_gap); end
            OP_STEP: begin mul_a = 33'(r_vt);      mul_b = {1'b0, r_dt}; end
            OP_KTS:  begin mul_a = {1'b0, r_kt};   mul_b = 33'(r_step); end
            OP_VISC: begin mul_a = {17'd0, r_dr};  mul_b = {1'b0, r_root}; end
            OP_VVN:  begin mul_a = {1'b0, r_visc}; mul_b = 33'(r_vn); end
            OP_THR:  begin mul_a = {17'd0, r_mu};  mul_b = 33'(r_fn); end
            OP_FX1:  begin mul_a = 33'(r_fn);      mul_b = 33'(r_nx); end
            OP_FX2:  begin mul_a = 33'(r_ft);      mul_b = 33'(r_tx); end
            OP_FY1:  begin mul_a = 33'(r_fn);      mul_b = 33'(r_ny); end
            OP_FY2:  begin mul_a = 33'(r_ft);      mul_b = 33'(r_ty); end
            OP_MOM1: begin mul_a = 33'(r_ly);      mul_b = 33'(r_fx); end
            OP_MOM2: begin mul_a = 33'(r_lx);      mul_b = 33'(r_fy); end
            default: begin mul_a = '0;             mul_b = '0; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb <= OP_NOP;
        end else begin
            r_wb <= i_cmd.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op != OP_NOP) begin
            r_prod <= mul_a * mul_b;
        end
    end

    // product writeback
    assign old_v = r_old_vld ? 66'(r_old) : 66'sd0;

    always_ff @(posedge i_clk) begin
        unique case (r_wb)
            OP_VN1, OP_VT1, OP_FX1, OP_FY1: r_acc <= r_prod;
            OP_VN2:  r_vn   <= sat32((r_acc + r_prod) >>> 14);
            OP_VT2:  r_vt   <= sat32((r_acc + r_prod) >>> 14);
            OP_KG:   r_kg   <= r_prod >>> 16;
            OP_STEP: r_step <= sat32(r_prod >>> 16);
            OP_KTS:  r_ft   <= sat32(old_v - (r_prod >>> 16));
            OP_VISC: r_visc <= (r_prod[65:43] != '0) ? 32'hFFFF_FFFF : r_prod[42:11];
            OP_VVN:  r_fn   <= sat32(-r_kg - (r_prod >>> 16));
            OP_THR:  r_thr  <= 38'(r_prod >>> 12);
            OP_FX2:  r_fx   <= sat32((r_acc + r_prod) >>> 14);
            OP_FY2:  r_fy   <= sat32((r_acc + r_prod) >>> 14);
            OP_MOM1: r_acc  <= r_prod >>> 16;
            default: ;
        endcase
        if (i_cmd.clamp) begin
            r_ft <= ft_sat;
        end
    end

    // friction cone clamp, upper bound first
    always_comb begin
        neg_thr  = -r_thr;
        clamp_lo = (38'(r_ft) > r_thr) ? r_thr : 38'(r_ft);
        clamp_v  = (clamp_lo < neg_thr) ? neg_thr : clamp_lo;
        ft_sat   = sat32(66'(clamp_v));
    end

    // bit-serial square root, two radicand bits per step
    assign rem_sh = {r_rem, r_rad[63:62]};
    assign trial  = {2'b00, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_busy <= 1'b0;
        end else if (r_wb == OP_MK) begin
            r_root_busy <= 1'b1;
            r_rad       <= r_prod[63:0];
            r_rem       <= '0;
            r_root      <= '0;
            r_cnt       <= '0;
        end else if (r_root_busy) begin
            r_rad <= {r_rad[61:0], 2'b00};
            if (rem_sh >= trial) begin
                r_rem  <= 34'(rem_sh - trial);
                r_root <= {r_root[30:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[33:0];
                r_root <= {r_root[30:0], 1'b0};
            end
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
                r_root_busy <= 1'b0;
            end
        end
    end

    // totals and result registers
    always_comb begin
        base_fx  = r_first ? 66'sd0 : 66'(r_sum_fx);
        base_fy  = r_first ? 66'sd0 : 66'(r_sum_fy);
        base_m   = r_first ? 66'sd0 : 66'(r_sum_m);
        mom_v    = r_acc - (r_prod >>> 16);
        sum_fx_n = r_contact ? sat32(base_fx - 66'(r_fx)) : base_fx[31:0];
        sum_fy_n = r_contact ? sat32(base_fy - 66'(r_fy)) : base_fy[31:0];
        sum_m_n  = r_contact ? sat32(base_m + mom_v) : base_m[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_fx <= '0;
            r_sum_fy <= '0;
            r_sum_m  <= '0;
        end else if (i_cmd.finish) begin
            r_sum_fx <= sum_fx_n;
            r_sum_fy <= sum_fy_n;
            r_sum_m  <= sum_m_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_con <= r_contact;
            r_out_fn  <= r_contact ? r_fn : 32'sd0;
            r_out_ft  <= r_contact ? r_ft : 32'sd0;
            r_out_px  <= r_contact ? r_fx : 32'sd0;
            r_out_py  <= r_contact ? r_fy : 32'sd0;
        end
    end

    assign o_in_contact       = r_out_con;
    assign o_normal_force     = r_out_fn;
    assign o_tangent_force    = r_out_ft;
    assign o_point_force_x    = r_out_px;
    assign o_point_force_y    = r_out_py;
    assign o_obstacle_force_x = r_sum_fx;
    assign o_obstacle_force_y = r_sum_fy;
    assign o_obstacle_moment  = r_sum_m;

endmodule

>>> src/spring_dashpot_friction_contact.sv
// ----------------------------------------------------------------------------
// spring_dashpot_friction_contact
// spring-dashpot normal force with Coulomb-limited tangential spring per contact
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  input     i_valid / o_stall      i_contact_slot .. i_first_of_sweep
//  output    o_valid / i_stall      o_in_contact .. o_obstacle_moment
//  config    i_cfg_we               i_cfg_idx, i_cfg_data
//
//  a touching contact is paced by the 32-step square root
//  and the chain of dependent operations on the one shared multiplier
//  a separated contact goes from the decide state straight to the final state
//  reset clears the sequencer, the slot valid bits and the running totals
//  a result beat waits in its register while stalled; the next beat is taken
//  meanwhile and holds in the final state until the register frees
module spring_dashpot_friction_contact (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    output logic                            o_valid,
    input  logic                            i_stall,
    input  logic                            i_cfg_we,
    input  logic [sdfc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [31:0]                     i_cfg_data,
    input  logic [sdfc_pkg::SLOT_W-1:0]     i_contact_slot,
    input  logic signed [31:0]              i_gap,
    input  logic signed [15:0]              i_normal_x,
    input  logic signed [15:0]              i_normal_y,
    input  logic signed [15:0]              i_tangent_x,
    input  logic signed [15:0]              i_tangent_y,
    input  logic signed [31:0]              i_rel_vel_x,
    input  logic signed [31:0]              i_rel_vel_y,
    input  logic [31:0]                     i_point_mass,
    input  logic signed [31:0]              i_lever_x,
    input  logic signed [31:0]              i_lever_y,
    input  logic                            i_first_of_sweep,
    output logic                            o_in_contact,
    output logic signed [31:0]              o_normal_force,
    output logic signed [31:0]              o_tangent_force,
    output logic signed [31:0]              o_point_force_x,
    output logic signed [31:0]              o_point_force_y,
    output logic signed [31:0]              o_obstacle_force_x,
    output logic signed [31:0]              o_obstacle_force_y,
    output logic signed [31:0]              o_obstacle_moment
);
    import sdfc_pkg::*;

    t_cmd cmd;
    t_sts sts;

    sdfc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    sdfc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_contact_slot     (i_contact_slot),
        .i_gap              (i_gap),
        .i_normal_x         (i_normal_x),
        .i_normal_y         (i_normal_y),
        .i_tangent_x        (i_tangent_x),
        .i_tangent_y        (i_tangent_y),
        .i_rel_vel_x        (i_rel_vel_x),
        .i_rel_vel_y        (i_rel_vel_y),
        .i_point_mass       (i_point_mass),
        .i_lever_x          (i_lever_x),
        .i_lever_y          (i_lever_y),
        .i_first_of_sweep   (i_first_of_sweep),
        .o_in_contact       (o_in_contact),
        .o_normal_force     (o_normal_force),
        .o_tangent_force    (o_tangent_force),
        .o_point_force_x    (o_point_force_x),
        .o_point_force_y    (o_point_force_y),
        .o_obstacle_force_x (o_obstacle_force_x),
        .o_obstacle_force_y (o_obstacle_force_y),
        .o_obstacle_moment  (o_obstacle_moment)
    );

endmodule
